[src/ifd_pkg.sv]
// shared constants and types for the imu binary frame deframer
package ifd_pkg;

   // frame layout
   localparam int FRAME_LEN      = 72;
   localparam int FIRST_WORD_OFS = 14;
   localparam int TEMP_OFS       = 66;
   localparam int NUM_FIELDS     = 14;

   // marker bytes
   localparam logic [7:0] HDR0  = 8'hA5;
   localparam logic [7:0] HDR1  = 8'h5A;
   localparam logic [7:0] TAIL0 = 8'h0D;
   localparam logic [7:0] TAIL1 = 8'h0A;

   // byte counter positions of interest
   localparam logic [6:0] CNT_HUNT  = 7'd0;
   localparam logic [6:0] CNT_HDR1  = 7'd1;
   localparam logic [6:0] CNT_FIRST = 7'(FIRST_WORD_OFS);
   localparam logic [6:0] CNT_END   = 7'(TEMP_OFS + 1);
   localparam logic [6:0] CNT_TAIL0 = 7'(FRAME_LEN - 2);
   localparam logic [6:0] CNT_LAST  = 7'(FRAME_LEN - 1);

   localparam logic [3:0] LAST_INDEX = 4'(NUM_FIELDS - 1);

   // one stored field word, byte 0 is the least significant
   typedef logic [3:0][7:0] word_type;

   // good frame handed from the collector to the emitter
   typedef struct packed {
      logic        start;
      logic        bank;
      logic [15:0] frame_num;
   } handoff_type;

endpackage

[src/ifd_collect.sv]
// byte collector: header hunt, frame checks, double-banked field store
module ifd_collect
   import ifd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        emit_busy,
   output handoff_type handoff,
   input  logic        rd_bank,
   input  logic [3:0]  rd_index,
   output word_type    rd_word
);

   logic [6:0]  count_ff, count_in;
   logic        hdr1_ok_ff, hdr1_ok_in;
   logic        tail0_ok_ff, tail0_ok_in;
   logic        bank_ff, bank_in;
   logic [15:0] frames_ff, frames_in;
   handoff_type handoff_ff, handoff_in;
   logic        accept;
   logic        good;
   logic        wr_en;
   logic [6:0]  wr_ofs;

   word_type store_ff [2][NUM_FIELDS];

   // hold the closing byte while the other bank is still being emitted
   assign req_ready = !(count_ff == CNT_LAST && emit_busy);
   assign accept    = req_valid && req_ready;

   // frame position tracking and checks
   always_comb begin
      count_in    = count_ff;
      hdr1_ok_in  = hdr1_ok_ff;
      tail0_ok_in = tail0_ok_ff;
      good        = 1'b0;
      if (accept) begin
         if (count_ff == CNT_HUNT) begin
            if (req_rx_byte == HDR0) begin
               count_in = CNT_HDR1;
            end
         end else if (count_ff == CNT_LAST) begin
            count_in = CNT_HUNT;
            good     = hdr1_ok_ff && tail0_ok_ff && (req_rx_byte == TAIL1);
         end else begin
            count_in = count_ff + 7'd1;
         end
         if (count_ff == CNT_HDR1) begin
            hdr1_ok_in = (req_rx_byte == HDR1);
         end
         if (count_ff == CNT_TAIL0) begin
            tail0_ok_in = (req_rx_byte == TAIL0);
         end
      end
   end

   // bank swap and frame count on a good frame
   always_comb begin
      bank_in              = good ? !bank_ff : bank_ff;
      frames_in            = good ? frames_ff + 16'd1 : frames_ff;
      handoff_in.start     = good;
      handoff_in.bank      = bank_ff;
      handoff_in.frame_num = frames_ff + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= CNT_HUNT;
         hdr1_ok_ff       <= 1'b0;
         tail0_ok_ff      <= 1'b0;
         bank_ff          <= 1'b0;
         frames_ff        <= '0;
         handoff_ff.start <= 1'b0;
      end else begin
         count_ff         <= count_in;
         hdr1_ok_ff       <= hdr1_ok_in;
         tail0_ok_ff      <= tail0_ok_in;
         bank_ff          <= bank_in;
         frames_ff        <= frames_in;
         handoff_ff.start <= handoff_in.start;
      end
      handoff_ff.bank      <= handoff_in.bank;
      handoff_ff.frame_num <= handoff_in.frame_num;
   end

   assign handoff = handoff_ff;

   // field bytes land at word = offset / 4, lane = offset % 4
   assign wr_ofs = count_ff - CNT_FIRST;
   assign wr_en  = accept && (count_ff >= CNT_FIRST) && (count_ff <= CNT_END);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[bank_ff][wr_ofs[5:2]][wr_ofs[1:0]] <= req_rx_byte;
      end
   end

   assign rd_word = store_ff[rd_bank][rd_index];

   // checks
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LAST)
      else $error("byte counter ran past the frame end");

   a_handoff_free : assert property (@(posedge clock) disable iff (reset)
      handoff_ff.start |-> !emit_busy)
      else $error("good frame handed over while emitter busy");

endmodule

[src/ifd_emit.sv]
// field emitter: walks the finished bank and fills the result register
module ifd_emit
   import ifd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  handoff_type handoff,
   output logic        emit_busy,
   output logic        rd_bank,
   output logic [3:0]  rd_index,
   input  word_type    rd_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_field_index,
   output logic [31:0] rsp_field_value,
   output logic [15:0] rsp_good_frame_number,
   output logic        rsp_last_field
);

   logic        busy_ff, busy_in;
   logic [3:0]  idx_ff, idx_in;
   logic        bank_ff, bank_in;
   logic [15:0] num_ff, num_in;
   logic        valid_ff, valid_in;
   logic [3:0]  index_ff, index_in;
   logic [31:0] value_ff, value_in;
   logic [15:0] frame_ff, frame_in;
   logic        last_ff, last_in;
   logic        load;

   // result register is free when empty or being taken
   assign load = busy_ff && (!valid_ff || rsp_ready);

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      bank_in  = bank_ff;
      num_in   = num_ff;
      valid_in = valid_ff && !rsp_ready;
      index_in = index_ff;
      value_in = value_ff;
      frame_in = frame_ff;
      last_in  = last_ff;
      if (handoff.start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         bank_in = handoff.bank;
         num_in  = handoff.frame_num;
      end else if (load) begin
         valid_in = 1'b1;
         index_in = idx_ff;
         frame_in = num_ff;
         last_in  = (idx_ff == LAST_INDEX);
         // temperature is int16, sign-extended
         if (idx_ff == LAST_INDEX) begin
            value_in = {{16{rd_word[1][7]}}, rd_word[1], rd_word[0]};
         end else begin
            value_in = rd_word;
         end
         idx_in = idx_ff + 4'd1;
         if (idx_ff == LAST_INDEX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bank_ff  <= bank_in;
      num_ff   <= num_in;
      index_ff <= index_in;
      value_ff <= value_in;
      frame_ff <= frame_in;
      last_ff  <= last_in;
   end

   assign emit_busy             = busy_ff;
   assign rd_bank               = bank_ff;
   assign rd_index              = idx_ff;
   assign rsp_valid             = valid_ff;
   assign rsp_field_index       = index_ff;
   assign rsp_field_value       = value_ff;
   assign rsp_good_frame_number = frame_ff;
   assign rsp_last_field        = last_ff;

   // checks
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      handoff.start |=> busy_ff && idx_ff == 4'd0)
      else $error("emitter did not start on a good frame");

   a_last_done : assert property (@(posedge clock) disable iff (reset)
      load && idx_ff == LAST_INDEX |=> !busy_ff && last_ff && valid_ff)
      else $error("final field did not close the frame");

endmodule

[src/imu_binary_frame_deframer_top.sv]
// top level of the imu binary frame deframer
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   req     | in        | req_valid / req_ready  | req_rx_byte
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_field_index, rsp_field_value,
//           |           |                        | rsp_good_frame_number, rsp_last_field
//
// one request byte per cycle while req_ready is high; a good 72-byte frame gives 14
// responses through the handoff register, one per cycle while rsp_ready is high
// the field store is double banked, so emission overlaps collection of the next frame
// req_ready drops only on the closing byte of a frame while the previous frame is
// still being emitted; synchronous reset returns to header hunt with the count at zero
module imu_binary_frame_deframer_top
   import ifd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_field_index,
   output logic [31:0] rsp_field_value,
   output logic [15:0] rsp_good_frame_number,
   output logic        rsp_last_field
);

   handoff_type handoff;
   logic        emit_busy;
   logic        rd_bank;
   logic [3:0]  rd_index;
   word_type    rd_word;

   // byte collection and frame checks
   ifd_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .emit_busy   (emit_busy),
      .handoff     (handoff),
      .rd_bank     (rd_bank),
      .rd_index    (rd_index),
      .rd_word     (rd_word)
   );

   // field emission
   ifd_emit u_emit (
      .clock                 (clock),
      .reset                 (reset),
      .handoff               (handoff),
      .emit_busy             (emit_busy),
      .rd_bank               (rd_bank),
      .rd_index              (rd_index),
      .rd_word               (rd_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_field_index       (rsp_field_index),
      .rsp_field_value       (rsp_field_value),
      .rsp_good_frame_number (rsp_good_frame_number),
      .rsp_last_field        (rsp_last_field)
   );

endmodule
